@@ hdl/acts_pkg.sv @@
`default_nettype none

package acts_pkg;

	// Field and register widths
	localparam int IDX_W     = 20;
	localparam int BYTE_W    = 8;
	localparam int NOTE_W    = 7;
	localparam int COUNT_W   = 3;
	localparam int CFG_IDX_W = 3;
	localparam int NOTE_REGS = 6;
	localparam int NSEL_W    = 3;
	localparam int MAX_NOTES = 6;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOTE_A     = 3'd1;

	// Harmonics 1, 2, 3, 5, 7
	localparam int HARM_N = 5;
	localparam int H_W    = 3;
	localparam logic [H_W-1:0] HARM_LAST = H_W'(HARM_N - 1);
	localparam int STEPS_W = IDX_W + 3;

	// Sine table, quarter wave stored
	localparam int SINE_BITS  = 10;
	localparam int QSIN_N     = 2 ** (SINE_BITS - 2);
	localparam int SINE_MAG_W = 9;
	localparam int SINE_W     = SINE_MAG_W + 1;
	localparam int M_W        = SINE_BITS - 1;

	// Shared multiplier
	localparam int MUL_A_W    = 24;
	localparam int MUL_B_W    = 33;
	localparam int MUL_FULL_W = MUL_A_W + MUL_B_W;
	localparam int MUL_P_W    = 40;

	// Fade: f = floor(idx * 8 / 25), by reciprocal
	localparam int FADE_DIV = 25;
	localparam int FADE_SH  = 24;
	localparam int FADE_X_W = 17;
	localparam int F_W      = 12;
	localparam logic [19:0] FADE_MUL = 20'(((1 << FADE_SH) + FADE_DIV - 1) / FADE_DIV);

	// Weights in 4.8
	localparam logic [F_W-1:0] W1_BASE = 12'd3840;
	localparam logic [F_W-1:0] W2_BASE = 12'd1920;
	localparam logic [F_W-1:0] W3_BASE = 12'd1280;
	localparam logic [F_W-1:0] W5_BASE = 12'd768;
	localparam logic [F_W-1:0] W7_BASE = 12'd512;
	localparam logic [F_W-1:0] W1_HOLD = 12'd3584;
	localparam logic [F_W-1:0] W2_HOLD = 12'd1280;
	localparam logic [F_W-1:0] W3_HOLD = 12'd1280;
	localparam logic [F_W-1:0] W5_HOLD = 12'd26;
	localparam logic [F_W-1:0] W7_HOLD = 12'd13;
	localparam logic [IDX_W-1:0] LIM_H1  = 20'd11200;
	localparam logic [IDX_W-1:0] LIM_H23 = 20'd4000;
	localparam logic [IDX_W-1:0] LIM_H5  = 20'd400;
	localparam logic [IDX_W-1:0] LIM_H7  = 20'd80;

	localparam int SUM_W = 24;
	localparam logic [BYTE_W-1:0] MID_LEVEL = 8'd127;

	// Pitch to phase rate
	localparam int SAMPLE_RATE = 8000;
	localparam logic [127:0] TURN_PER_HZ = 128'd4294840626;
	localparam logic [127:0] PITCH_DIV   = 128'd10000000 * 128'(SAMPLE_RATE);
	localparam logic [31:0] BASE_PITCH [12] = '{
		32'd1100000000, 32'd1165409403, 32'd1234708252, 32'd1308127825,
		32'd1385913153, 32'd1468323837, 32'd1555634915, 32'd1648137780,
		32'd1746141152, 32'd1849972107, 32'd1959977172, 32'd2076523479
	};

	typedef logic [31:0] rate_tab_t [128];
	typedef logic [SINE_MAG_W-1:0] qsin_tab_t [QSIN_N];

	function automatic rate_tab_t build_rates();
		rate_tab_t  tab;
		logic [127:0] pu;
		logic [127:0] q;
		int n;
		int oct;
		for (n = 0; n < 128; n++) begin
			oct = n / 12;
			pu  = 128'(BASE_PITCH[n % 12]) << ((oct <= 5) ? oct : 0);
			q   = (pu * TURN_PER_HZ) / PITCH_DIV;
			tab[n] = q[31:0];
		end
		return tab;
	endfunction

	// Odd polynomial in Q16, rounded to 1.8
	function automatic logic [SINE_MAG_W-1:0] sine_mag(input int m);
		longint u;
		longint u2;
		longint t;
		longint y;
		u  = longint'(m) << (18 - SINE_BITS);
		u2 = (u * u) >>> 16;
		t  = 64'sd5223 - ((64'sd307 * u2) >>> 16);
		t  = 64'sd42334 - ((t * u2) >>> 16);
		t  = 64'sd102944 - ((t * u2) >>> 16);
		y  = (t * u) >>> 16;
		y  = (y + 64'sd128) >>> 8;
		return SINE_MAG_W'(y);
	endfunction

	function automatic qsin_tab_t build_qsin();
		qsin_tab_t tab;
		int m;
		for (m = 0; m < QSIN_N; m++) begin
			tab[m] = sine_mag(m);
		end
		return tab;
	endfunction

	localparam rate_tab_t RATE_TAB = build_rates();
	localparam qsin_tab_t QSIN_TAB = build_qsin();
	localparam logic [SINE_MAG_W-1:0] SIN_PEAK = sine_mag(QSIN_N);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FADE,
		ST_WGT,
		ST_PHASE,
		ST_LOOK,
		ST_MAC,
		ST_NOTE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [COUNT_W-1:0]                 count;
		logic [NOTE_REGS-1:0][NOTE_W-1:0]   note;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} res_t;

	typedef struct packed {
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage

`default_nettype wire

@@ hdl/additive_chord_tone_synth_top.sv @@
// Channel    Direction  Payload (low bit up)           Handshake
// s_*        in         s_tdata: sample_index[19:0]    s_tvalid / s_tready
// m_*        out        m_tdata: sample_byte[7:0]      m_tvalid / m_tready
// cfg_*      in         cfg_data: register value       cfg_we, index cfg_index
//
// An accepted request with c notes (c = note_count, clamped to six) keeps the
// block busy while each of the 5*c harmonic terms passes through three steps on
// the one shared multiplier (phase, sine lookup, weighting) and each note takes
// one more step to close its sum.
// A request with note_count zero is taken, leaves the block ready and yields no result.
// The result sits in an output register, so a new request is taken while it
// waits; the sequencer holds in its last step only if that register is full.
// Asynchronous reset zeroes the config and output valid, and idles the sequencer.
`default_nettype none

module additive_chord_tone_synth_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [23:0]                          s_tdata,   // [19:0] sample_index
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [7:0]                           m_tdata,   // [7:0] sample_byte
	input  logic                                 cfg_we,
	input  logic [acts_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [acts_pkg::NOTE_W-1:0]          cfg_data
);
	import acts_pkg::*;

	cfg_t              cfg_q;
	res_t              res;
	logic              core_ready;
	logic              out_free;
	logic              m_tvalid_q;
	logic [BYTE_W-1:0] m_tdata_q;

	// Register file: note count plus six note numbers, writes past the list drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_NOTE_COUNT) begin
				cfg_q.count <= cfg_data[COUNT_W-1:0];
			end
			for (int i = 0; i < NOTE_REGS; i++) begin
				if (cfg_index == REG_NOTE_A + CFG_IDX_W'(i)) begin
					cfg_q.note[i] <= cfg_data;
				end
			end
		end
	end

	// Output register is free when empty or draining this cycle
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = core_ready;

	acts_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (s_tvalid && core_ready),
		.idx      (s_tdata[IDX_W-1:0]),
		.cfg      (cfg_q),
		.out_free (out_free),
		.ready    (core_ready),
		.res      (res)
	);

	// Hold the sample until the downstream side takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			m_tdata_q <= res.data;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

@@ hdl/acts_mul.sv @@
`default_nettype none

module acts_mul (
	input  logic                                clk,
	input  acts_pkg::mul_req_t                  req,
	output logic signed [acts_pkg::MUL_P_W-1:0] p_q
);
	import acts_pkg::*;

	logic signed [MUL_FULL_W-1:0] prod;

	assign prod = req.a * req.b;

	always_ff @(posedge clk) begin
		p_q <= prod[MUL_P_W-1:0];
	end

endmodule

`default_nettype wire

@@ hdl/acts_core.sv @@
`default_nettype none

module acts_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [acts_pkg::IDX_W-1:0]    idx,
	input  acts_pkg::cfg_t                cfg,
	input  logic                          out_free,
	output logic                          ready,
	output acts_pkg::res_t                res
);
	import acts_pkg::*;

	state_t state_q, state_d;

	logic [IDX_W-1:0]         idx_q;
	logic [COUNT_W-1:0]       cnt_q;
	logic [NSEL_W-1:0]        n_q;
	logic [H_W-1:0]           h_q;
	logic [F_W-1:0]           f_q;
	logic [31:0]              rate_q;
	logic signed [SINE_W-1:0] sine_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [BYTE_W-1:0]        acc_q;

	mul_req_t                   mul_req;
	logic signed [MUL_P_W-1:0]  mul_p;

	logic [COUNT_W-1:0]       cnt_in;
	logic                     last;
	logic [NSEL_W-1:0]        n_next;
	logic [STEPS_W-1:0]       steps;
	logic [F_W-1:0]           weight;
	logic [SINE_BITS-1:0]     j;
	logic [M_W-1:0]           m;
	logic [SINE_MAG_W-1:0]    mag;
	logic signed [SINE_W-1:0] sine_d;
	logic signed [SUM_W-1:0]  total;
	logic [BYTE_W-1:0]        note_v;

	acts_mul u_mul (
		.clk (clk),
		.req (mul_req),
		.p_q (mul_p)
	);

	assign cnt_in = (cfg.count > COUNT_W'(MAX_NOTES)) ? COUNT_W'(MAX_NOTES) : cfg.count;
	assign last   = (COUNT_W'(n_q) == cnt_q - COUNT_W'(1));
	assign n_next = n_q + NSEL_W'(1);

	always_comb begin
		unique case (h_q)
			3'd0:    steps = STEPS_W'(idx_q);
			3'd1:    steps = STEPS_W'(idx_q) << 1;
			3'd2:    steps = STEPS_W'(idx_q) + (STEPS_W'(idx_q) << 1);
			3'd3:    steps = STEPS_W'(idx_q) + (STEPS_W'(idx_q) << 2);
			default: steps = (STEPS_W'(idx_q) << 3) - STEPS_W'(idx_q);
		endcase
	end

	always_comb begin
		unique case (h_q)
			3'd0:    weight = W1_BASE - ((idx_q < LIM_H1)  ? f_q : W1_HOLD);
			3'd1:    weight = W2_BASE - ((idx_q < LIM_H23) ? f_q : W2_HOLD);
			3'd2:    weight = W3_BASE - ((idx_q < LIM_H23) ? f_q : W3_HOLD);
			3'd3:    weight = W5_BASE - ((idx_q < LIM_H5)  ? f_q : W5_HOLD);
			default: weight = W7_BASE - ((idx_q < LIM_H7)  ? f_q : W7_HOLD);
		endcase
	end

	// Quarter-wave lookup: mirror odd quarters, negate the second half
	assign j      = mul_p[31 -: SINE_BITS];
	assign m      = j[SINE_BITS-2] ? (M_W'(QSIN_N) - M_W'(j[SINE_BITS-3:0]))
	                               : M_W'(j[SINE_BITS-3:0]);
	assign mag    = (m == M_W'(QSIN_N)) ? SIN_PEAK : QSIN_TAB[m[SINE_BITS-3:0]];
	assign sine_d = j[SINE_BITS-1] ? (SINE_W'(0) - {1'b0, mag}) : {1'b0, mag};

	// Cut the note sum toward zero, keep eight bits
	assign total  = sum_q + mul_p[SUM_W-1:0];
	assign note_v = total[SUM_W-1 -: BYTE_W]
	              + BYTE_W'(total[SUM_W-1] && (total[15:0] != 16'd0));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start && (cnt_in != '0)) state_d = ST_FADE;
			ST_FADE:  state_d = ST_WGT;
			ST_WGT:   state_d = ST_PHASE;
			ST_PHASE: state_d = ST_LOOK;
			ST_LOOK:  state_d = ST_MAC;
			ST_MAC:   state_d = (h_q == HARM_LAST) ? ST_NOTE : ST_PHASE;
			ST_NOTE:  state_d = last ? ST_DONE : ST_PHASE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ready     = (state_q == ST_IDLE);
		res.valid = (state_q == ST_DONE) && out_free;
		res.data  = acc_q;
		mul_req.a = '0;
		mul_req.b = '0;
		unique case (state_q)
			ST_FADE: begin
				mul_req.a = MUL_A_W'({idx_q[13:0], 3'b000});
				mul_req.b = MUL_B_W'(FADE_MUL);
			end
			ST_PHASE: begin
				mul_req.a = MUL_A_W'(steps);
				mul_req.b = MUL_B_W'(rate_q);
			end
			ST_MAC: begin
				mul_req.a = MUL_A_W'(weight);
				mul_req.b = MUL_B_W'(sine_q);
			end
			default: begin
				mul_req.a = '0;
				mul_req.b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			h_q     <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= cnt_in;
					n_q   <= '0;
					h_q   <= '0;
				end
				ST_MAC: if (h_q != HARM_LAST) h_q <= h_q + H_W'(1);
				ST_NOTE: begin
					h_q <= '0;
					if (!last) n_q <= n_next;
				end
				default: begin
					h_q <= h_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				idx_q <= idx;
				acc_q <= MID_LEVEL;
			end
			ST_WGT: begin
				f_q    <= mul_p[FADE_SH +: F_W];
				rate_q <= RATE_TAB[cfg.note[0]];
				sum_q  <= '0;
			end
			ST_PHASE: if (h_q != '0) sum_q <= sum_q + mul_p[SUM_W-1:0];
			ST_LOOK:  sine_q <= sine_d;
			ST_NOTE: begin
				acc_q <= acc_q + note_v;
				sum_q <= '0;
				if (!last) rate_q <= RATE_TAB[cfg.note[n_next]];
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hdl/acts_chk.sv @@
`default_nettype none

module acts_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [7:0]                      m_tdata,
	input logic                            cfg_we,
	input logic [acts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [acts_pkg::NOTE_W-1:0]     cfg_data
);
	import acts_pkg::*;

	logic cnt_nz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_nz_q <= 1'b0;
		end else if (cfg_we && (cfg_index == REG_NOTE_COUNT)) begin
			cnt_nz_q <= (cfg_data[COUNT_W-1:0] != '0);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped or changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && cnt_nz_q |=> !s_tready)
		else $error("request taken while a chord is being summed");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared straight after a request");

	a_empty_chord: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !cnt_nz_q |=> s_tready)
		else $error("empty chord left the block busy");

endmodule

bind additive_chord_tone_synth_top acts_chk u_acts_chk (.*);

`default_nettype wire
